[rtl/lsil_pkg.sv]
// Package for the log-spaced interpolation lookup: widths, codes and constants.
// No dependencies.
`timescale 1ns / 1ps
package lsil_pkg;
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;

  // Squaring rounds of the log2 mantissa, and the register stages of the whole pipeline.
  localparam int LOG_ROUNDS = 16;
  localparam int PIPE_DEPTH = LOG_ROUNDS + 7;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_INTERP = 2'd1;
  localparam logic [1:0] OP_BIN = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_CLAMP = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [2:0] REG_LOG_START = 3'd0;
  localparam logic [2:0] REG_INCS = 3'd1;
  localparam logic [2:0] REG_START = 3'd2;
  localparam logic [2:0] REG_INV_START = 3'd3;
  localparam logic [2:0] REG_MAX = 3'd4;

  // Control that rides along with each item through the pipeline.
  typedef struct packed {
    logic [1:0] op;
    logic       special;   // result fixed, no table read
    logic [1:0] st;
    logic       below;     // below-start interpolation
    logic       last;      // segment past table end
  } ctl_t;
endpackage

[rtl/lsil_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lsil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

[rtl/lsil_log_stage.sv]
// One mantissa squaring round of the fixed-point log2, registered.
// Depends on lsil_pkg.
`timescale 1ns / 1ps
module lsil_log_stage import lsil_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [32:0] x_in,
  input  logic [15:0] frac_in,
  output logic [32:0] x_out,
  output logic [15:0] frac_out
);
  logic [65:0] sq;
  logic [34:0] sh;
  always_comb begin
    sq = x_in * x_in;
    sh = sq[65:31];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (sh[32]) begin
        x_out <= sh[33:1];
        frac_out <= {frac_in[14:0], 1'b1};
      end else begin
        x_out <= sh[32:0];
        frac_out <= {frac_in[14:0], 1'b0};
      end
    end
  end
endmodule

[rtl/log_spaced_interp_lookup.sv]
// Top level of the log-spaced interpolation lookup.
// Depends on lsil_pkg, lsil_log_stage and lsil_ram.
`timescale 1ns / 1ps
// Usage: items enter on the in channel (in_valid/in_ready) with an operation,
// an entry index and value for loads, and a distance for queries. Each item
// gives one beat on the out channel (out_valid/out_ready): result_value and
// status. Loads write the sample table and return zero. Interpolated queries
// take log10 of the clamped distance and blend two neighboring entries; bin
// queries return one entry. Configuration registers are written on the cfg
// channel (cfg_valid/cfg_ready, cfg_index, cfg_data); the user must write
// them only while the block is idle, which the block does not enforce. Throughput
// is one item per cycle while out_ready does not stall the output. The 23
// register stages are: one input stage, 16 squaring stages of the log2 mantissa
// (one multiplier each), a log10 multiply, a segment multiply, table read,
// difference, blend multiply and output add. The whole pipeline advances
// together; when the receiver holds out_ready low and the output register is
// full, every stage holds, so no beat is lost or repeated. Reset clears all
// valid bits and restores the register defaults; the sample table is not
// cleared and must be loaded before it is read.
module log_spaced_interp_lookup import lsil_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [9:0]         entry_index,
  input  logic signed [31:0] entry_value,
  input  logic [31:0]        distance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_value,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  logic signed [23:0] log_start;
  logic [15:0]        steps_per_decade;
  logic [31:0]        start_distance, inv_start, max_distance;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      log_start <= '0;
      steps_per_decade <= 16'd256;
      start_distance <= 32'd65536;
      inv_start <= 32'd65536;
      max_distance <= 32'hFFFF_FFFF;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LOG_START: log_start <= cfg_data[23:0];
        REG_INCS:      steps_per_decade <= cfg_data[15:0];
        REG_START:     start_distance <= cfg_data;
        REG_INV_START: inv_start <= cfg_data;
        REG_MAX:       max_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  // Single global enable: the pipeline moves unless the output beat is stuck.
  logic adv;
  logic [PIPE_DEPTH-1:0] vld;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[PIPE_DEPTH-2:0], in_valid};
  end
  assign out_valid = vld[PIPE_DEPTH-1];

  // Per-stage side data, shifted along in lockstep as far as it is needed.
  ctl_t        ctl [LOG_ROUNDS+2];
  logic [31:0] dpipe [LOG_ROUNDS+2];
  logic [9:0]  lidx [LOG_ROUNDS+3];
  logic [31:0] lval [LOG_ROUNDS+3];
  logic [4:0]  lpos [LOG_ROUNDS+1];

  // Stage 0: clamp, zero checks, leading-one position and normalization.
  logic [31:0] dcl;
  logic [4:0]  p;
  ctl_t        c0;
  logic [32:0] x0;
  always_comb begin
    c0 = '0;
    c0.op = operation;
    dcl = distance;
    p = '0;
    for (int k = 0; k < 32; k++) if (distance[k]) p = 5'(k);
    if (operation == OP_INTERP) begin
      if (distance > max_distance) begin
        dcl = max_distance;
        c0.st = ST_CLAMP;
      end
      if (dcl == 32'd0) begin
        c0.st = ST_ZERO;
        c0.special = 1'b1;
      end
    end else if (operation == OP_BIN) begin
      if (distance == 32'd0 || distance >= max_distance || distance < start_distance) begin
        c0.st = ST_RANGE;
        c0.special = 1'b1;
      end
    end else begin
      c0.special = 1'b1;
    end
    p = '0;
    for (int k = 0; k < 32; k++) if (dcl[k]) p = 5'(k);
    x0 = {1'b0, dcl << (5'd31 - p)};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl[0] <= c0;
      dpipe[0] <= dcl;
      lidx[0] <= entry_index;
      lval[0] <= entry_value;
      lpos[0] <= p;
      for (int s = 1; s < LOG_ROUNDS + 2; s++) begin
        ctl[s] <= ctl[s-1];
        dpipe[s] <= dpipe[s-1];
      end
      for (int s = 1; s < LOG_ROUNDS + 3; s++) begin
        lidx[s] <= lidx[s-1];
        lval[s] <= lval[s-1];
      end
      for (int s = 1; s < LOG_ROUNDS + 1; s++) lpos[s] <= lpos[s-1];
    end
  end

  // Stages 1..16: squaring rounds, fed from the stage-0 mantissa register.
  logic [32:0] xs [LOG_ROUNDS+1];
  logic [15:0] fs [LOG_ROUNDS+1];
  logic [32:0] x_r;
  always_ff @(posedge clk) if (adv) x_r <= x0;
  assign xs[0] = x_r;
  assign fs[0] = '0;
  for (genvar g = 0; g < LOG_ROUNDS; g++) begin : g_log
    lsil_log_stage u_st (
      .clk(clk), .en(adv),
      .x_in(xs[g]),
      .frac_in(fs[g]),
      .x_out(xs[g+1]), .frac_out(fs[g+1])
    );
  end

  // Stage 17: log10 = floor((L2 - 16*2^16) * C / 2^32), L2 relative.
  logic signed [22:0] l2rel;
  logic signed [55:0] lprod;
  logic signed [31:0] logd;
  assign l2rel = $signed({2'b00, lpos[LOG_ROUNDS], fs[LOG_ROUNDS]}) - 23'sd1048576;
  assign lprod = l2rel * $signed({1'b0, LOG10_2_Q32});
  always_ff @(posedge clk) if (adv) begin
    logd <= 32'(lprod >>> 32);
  end

  // Stage 18: segment position t and below-start ratio.
  logic signed [32:0] ldiff;
  logic [48:0] t;
  logic [63:0] ratio_full;
  logic [16:0] ratio;
  ctl_t        c18, c18_next;
  assign ldiff = 33'(logd) - 33'(log_start);
  always_comb begin
    c18_next = ctl[LOG_ROUNDS+1];
    c18_next.below = ldiff[32];
  end
  always_ff @(posedge clk) if (adv) begin
    t <= ldiff[32] ? '0 : 49'(ldiff[31:0]) * 49'(steps_per_decade);
    ratio_full <= dpipe[LOG_ROUNDS+1] * inv_start;
    c18 <= c18_next;
  end

  // Stage 19: index choice and table read address.
  logic [48:0]      ipos;
  logic [IDX_W-1:0] ra0;
  logic             rd_last;
  ctl_t             c19;
  logic [15:0]      fr19;
  logic [16:0]      rat19;
  always_comb begin
    c19 = c18;
    rd_last = 1'b0;
    ipos = t >> 24;
    ra0 = '0;
    ratio = (ratio_full[63:16] > 48'd65536) ? 17'd65536 : ratio_full[32:16];
    if (c18.op == OP_BIN) begin
      if (!c18.special) begin
        if (c18.below) ra0 = '0;
        else if (ipos >= 49'(TABLE_DEPTH)) begin
          c19.special = 1'b1;
          c19.st = ST_RANGE;
        end else ra0 = ipos[IDX_W-1:0];
      end
      c19.below = 1'b0;
    end else if (c18.below) ra0 = '0;
    else if (ipos + 49'd2 > 49'(TABLE_DEPTH - 1)) begin
      rd_last = 1'b1;
      ra0 = IDX_W'(TABLE_DEPTH - 1);
    end else ra0 = ipos[IDX_W-1:0] + 1'b1;
    c19.last = rd_last;
  end

  // Memory: two banks written together give a second read port.
  logic             we;
  logic [31:0]      rd0, rd1;
  logic [IDX_W-1:0] ra1;
  assign we = adv && vld[LOG_ROUNDS+2] && c18.op == OP_LOAD;
  assign ra1 = ra0 + 1'b1;
  lsil_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_bank0 (
    .clk(clk), .we(we), .waddr(lidx[LOG_ROUNDS+2][IDX_W-1:0]),
    .wdata(lval[LOG_ROUNDS+2]), .re(adv), .raddr(ra0), .rdata(rd0));
  lsil_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_bank1 (
    .clk(clk), .we(we), .waddr(lidx[LOG_ROUNDS+2][IDX_W-1:0]),
    .wdata(lval[LOG_ROUNDS+2]), .re(adv), .raddr(ra1), .rdata(rd1));

  ctl_t c20, c21, c22;
  logic [15:0] fr20, fr21;
  logic [16:0] rat20, rat21;
  assign fr19 = t[23:8];
  assign rat19 = ratio;
  always_ff @(posedge clk) if (adv) begin
    c20 <= c19; fr20 <= fr19; rat20 <= rat19;
  end

  // Stage 20: difference.
  logic signed [31:0] lb21;
  logic signed [32:0] df21;
  always_ff @(posedge clk) if (adv) begin
    c21 <= c20; fr21 <= fr20; rat21 <= rat20;
    lb21 <= rd0;
    df21 <= 33'($signed(rd1)) - 33'($signed(rd0));
  end

  // Stage 21: blend multiply.
  logic signed [31:0] lb22;
  logic signed [50:0] pr22;
  logic signed [17:0] wgt;
  assign wgt = c21.below ? $signed({1'b0, rat21}) : $signed({2'b0, fr21});
  always_ff @(posedge clk) if (adv) begin
    c22 <= c21; lb22 <= lb21;
    pr22 <= df21 * wgt;
  end

  // Stage 22: output add.
  always_ff @(posedge clk) if (adv) begin
    status <= c22.st;
    if (c22.special) result_value <= '0;
    else if (c22.op == OP_BIN || c22.last) result_value <= lb22;
    else result_value <= lb22 + 32'(pr22 >>> 16);
  end

  // A stalled output never lets the pipeline move.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(status))
    else $error("output beat changed while stalled");
  assert property (@(posedge clk) disable iff (rst) in_ready == adv)
    else $error("input ready out of step with the pipeline");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ZERO || status == ST_RANGE) |-> result_value == '0)
    else $error("error status returned a nonzero value");
endmodule

[dv/log_spaced_interp_lookup_tb.sv]
// Testbench for log_spaced_interp_lookup: loads, interpolated and bin queries
// checked beat by beat against a predictor kept inside this file.
// Depends on lsil_pkg and the RTL of log_spaced_interp_lookup.
`timescale 1ns / 1ps
module log_spaced_interp_lookup_tb;
  import lsil_pkg::*;

  // One input beat as the driver presents it.
  typedef struct {
    logic [1:0]         op;
    logic [9:0]         idx;
    logic signed [31:0] val;
    logic [31:0]        qdist;
  } lookup_req_t;

  // One output beat as the predictor expects it.
  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         st;
  } lookup_resp_t;

  localparam int IDLE_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] operation = OP_LOAD;
  logic [9:0] entry_index = '0;
  logic signed [31:0] entry_value = '0;
  logic [31:0] distance = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] result_value;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_LOG_START;
  logic [31:0] cfg_data = '0;

  log_spaced_interp_lookup dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .entry_index(entry_index),
    .entry_value(entry_value), .distance(distance),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_value(result_value), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Shadow of the block's state: the sample table and the five registers.
  logic signed [31:0] samples [TABLE_DEPTH];
  logic [23:0] sh_log_start = 24'd0;
  logic [15:0] sh_incs = 16'd256;
  logic [31:0] sh_start = 32'd65536;
  logic [31:0] sh_inv_start = 32'd65536;
  logic [31:0] sh_max = 32'hFFFF_FFFF;

  lookup_req_t pending_reqs[$];
  lookup_resp_t expected_resps[$];
  lookup_req_t cur_req;
  int errors = 0;
  bit stim_done = 1'b0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // log10 of a nonzero Q16.16 distance, in Q8.16, rounded toward minus infinity.
  // The log2 fraction comes from repeated squaring of the normalized mantissa.
  function automatic longint log10_q16(input logic [31:0] d);
    int p;
    int k;
    logic [63:0] x;
    logic [15:0] frac;
    logic [63:0] l2;
    logic [63:0] acc;
    logic [63:0] off;
    p = 31;
    while (p > 0 && d[p] == 1'b0) p--;
    x = 64'(d) << (31 - p);
    frac = '0;
    for (k = 0; k < 16; k++) begin
      x = (x * x) >> 31;
      frac = {frac[14:0], 1'b0};
      if (x[63:32] != 0) begin
        frac[0] = 1'b1;
        x = x >> 1;
      end
    end
    l2 = (64'(p) << 16) | 64'(frac);
    acc = l2 * 64'(LOG10_2_Q32);
    off = (64'd1 << 20) * 64'(LOG10_2_Q32);
    return longint'((acc + (64'd1 << 52) - off) >> 32) - (longint'(1) << 20);
  endfunction

  function automatic lookup_resp_t predict_lookup(input lookup_req_t rq);
    lookup_resp_t r;
    logic [31:0] d;
    longint ls;
    longint logd;
    longint lb;
    longint ub;
    logic [63:0] t;
    logic [63:0] ratio;
    logic [63:0] i;
    r.value = '0;
    r.st = ST_OK;
    d = rq.qdist;
    ls = longint'($signed(sh_log_start));
    case (rq.op)
      OP_INTERP: begin
        if (d == 0) begin
          r.st = ST_ZERO;
        end else begin
          if (d > sh_max) begin
            d = sh_max;
            r.st = ST_CLAMP;
          end
          if (d == 0) begin
            r.st = ST_ZERO;
          end else begin
            logd = log10_q16(d);
            if (logd < ls) begin
              // Below the first sample point: blend entries 0 and 1 by d/start.
              ratio = (64'(d) * 64'(sh_inv_start)) >> 16;
              if (ratio > 64'd65536) ratio = 64'd65536;
              lb = longint'(samples[0]);
              ub = longint'(samples[1]);
              r.value = 32'(lb + (((ub - lb) * longint'(ratio)) >>> 16));
            end else begin
              t = 64'(logd - ls) * 64'(sh_incs);
              i = (t >> 24) + 1;
              if (i + 1 > TABLE_DEPTH - 1) begin
                r.value = samples[TABLE_DEPTH-1];
              end else begin
                lb = longint'(samples[i]);
                ub = longint'(samples[i+1]);
                r.value = 32'(lb + (((ub - lb) * longint'(t[23:8])) >>> 16));
              end
            end
          end
        end
      end
      OP_BIN: begin
        if (d == 0 || d >= sh_max || d < sh_start) begin
          r.st = ST_RANGE;
        end else begin
          logd = log10_q16(d);
          i = 0;
          if (logd > ls) i = (64'(logd - ls) * 64'(sh_incs)) >> 24;
          if (i >= TABLE_DEPTH) r.st = ST_RANGE;
          else r.value = samples[i];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Distances spread over all magnitudes, with the edges around start and max.
  function automatic logic [31:0] pick_distance();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return sh_max + 32'($urandom_range(0, 2)) - 32'd1;
      2: return sh_start + 32'($urandom_range(0, 2)) - 32'd1;
      3: return 32'hFFFF_FFFF;
      4, 5: return $urandom;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic lookup_req_t rand_req();
    lookup_req_t rq;
    int sel;
    sel = $urandom_range(0, 19);
    rq.op = (sel < 3) ? OP_LOAD : (sel < 11) ? OP_INTERP : (sel < 19) ? OP_BIN : OP_UNUSED;
    rq.idx = 10'($urandom);
    rq.val = $urandom;
    rq.qdist = pick_distance();
    return rq;
  endfunction

  function automatic lookup_req_t make_req(input logic [1:0] op, input logic [9:0] idx,
                                           input logic [31:0] val, input logic [31:0] qdist);
    lookup_req_t rq;
    rq.op = op;
    rq.idx = idx;
    rq.val = val;
    rq.qdist = qdist;
    return rq;
  endfunction

  // Register writes happen only with the pipeline empty.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [31:0] ls, input logic [15:0] incs,
                          input logic [31:0] start, input logic [31:0] inv,
                          input logic [31:0] maxd);
    write_reg(REG_LOG_START, ls);
    write_reg(REG_INCS, 32'(incs));
    write_reg(REG_START, start);
    write_reg(REG_INV_START, inv);
    write_reg(REG_MAX, maxd);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_resps.size() != 0)
      @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // Stimulus: fill the table, directed corners, then phases of random beats.
  initial begin
    int ph;
    int n;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_regs(32'd0, 16'd256, 32'd65536, 32'd65536, 32'hFFFF_FFFF);
    // Every entry is loaded first, so no query can read an unwritten entry.
    for (n = 0; n < TABLE_DEPTH; n++)
      pending_reqs.push_back(make_req(OP_LOAD, 10'(n), $urandom, $urandom));
    pending_reqs.push_back(make_req(OP_LOAD, 10'd0, 32'h8000_0000, 32'd0));
    pending_reqs.push_back(make_req(OP_LOAD, 10'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(OP_LOAD, 10'd1023, 32'h8000_0000, 32'd0));
    pending_reqs.push_back(make_req(OP_INTERP, 10'd0, 32'd0, 32'd0));
    pending_reqs.push_back(make_req(OP_INTERP, 10'd0, 32'd0, 32'd1));
    pending_reqs.push_back(make_req(OP_INTERP, 10'd0, 32'd0, 32'd32768));
    pending_reqs.push_back(make_req(OP_INTERP, 10'd0, 32'd0, 32'd65536));
    pending_reqs.push_back(make_req(OP_INTERP, 10'd0, 32'd0, 32'd655360));
    pending_reqs.push_back(make_req(OP_INTERP, 10'd0, 32'd0, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(OP_BIN, 10'd0, 32'd0, 32'd0));
    pending_reqs.push_back(make_req(OP_BIN, 10'd0, 32'd0, 32'd65535));
    pending_reqs.push_back(make_req(OP_BIN, 10'd0, 32'd0, 32'd65536));
    pending_reqs.push_back(make_req(OP_BIN, 10'd0, 32'd0, 32'hFFFF_FFFE));
    pending_reqs.push_back(make_req(OP_BIN, 10'd0, 32'd0, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(OP_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    drain();

    // Extreme settings first, then realistic ones and fully random ones.
    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_regs(32'hFF80_0000, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 32'd0);
        1: set_regs(32'h007F_FFFF, 16'd1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        2: set_regs(-32'sd131072, 16'($urandom_range(4, 64) * 256), 32'd655,
                    32'd6553600, 32'h0100_0000 + ($urandom >> 8));
        3: set_regs(32'd0, 16'($urandom_range(1, 200) * 256), 32'd65536, 32'd65536,
                    $urandom);
        4: set_regs(32'($signed(-($urandom_range(0, 5) * 65536))), 16'd256 * 16'd20,
                    32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: set_regs($urandom, 16'($urandom_range(1, 65535)), $urandom >> 8,
                          $urandom, $urandom);
      endcase
      for (n = 0; n < 95; n++) pending_reqs.push_back(rand_req());
      drain();
    end
    stim_done = 1'b1;
  end

  // Driver: bursts of beats separated by random gaps, valid held until taken.
  logic in_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // Still waiting for the block to take the current beat.
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_reqs.size() != 0) begin
      cur_req = pending_reqs.pop_front();
      in_valid <= 1'b1;
      operation <= cur_req.op;
      entry_index <= cur_req.idx;
      entry_value <= cur_req.val;
      distance <= cur_req.qdist;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, with long stretches of steady ready now and then.
  int ready_run = 0;
  bit steady = 1'b0;
  always @(negedge clk) begin
    if (ready_run == 0) begin
      ready_run = $urandom_range(1, 60);
      steady = ($urandom_range(0, 2) == 0);
    end else begin
      ready_run--;
    end
    out_ready <= rst ? 1'b0 : (steady || $urandom_range(0, 3) != 0);
  end

  // Monitor: predict on each accepted input beat, check each output beat.
  always @(posedge clk) begin
    lookup_resp_t exp_r;
    in_taken <= in_valid && in_ready && !rst;
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOG_START: sh_log_start = cfg_data[23:0];
        REG_INCS: sh_incs = cfg_data[15:0];
        REG_START: sh_start = cfg_data;
        REG_INV_START: sh_inv_start = cfg_data;
        REG_MAX: sh_max = cfg_data;
        default: ;
      endcase
    end
    if (!rst && in_valid && in_ready) begin
      expected_resps.push_back(predict_lookup(cur_req));
      if (cur_req.op == OP_LOAD) samples[cur_req.idx] = cur_req.val;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_resps.size() == 0) begin
        report_mismatch("output beat with nothing expected");
      end else begin
        exp_r = expected_resps.pop_front();
        if (result_value !== exp_r.value)
          report_mismatch($sformatf("result_value %h, expected %h", result_value,
                                    exp_r.value));
        if (status !== exp_r.st)
          report_mismatch($sformatf("status %0d, expected %0d", status, exp_r.st));
      end
    end
  end

  // Watchdog on cycles in which no channel moves a beat; also the final verdict.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (stim_done) begin
      if (errors == 0 && expected_resps.size() == 0) begin
        $display("Simulation PASSED");
      end else begin
        $display("Simulation FAILED");
      end
      $finish;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end
endmodule
